/* rtl/core/lge_pkg.sv */
// ----------------------------------------------------------------------------
// lge_pkg
// shared types and constants of the life generation engine: request and
// response words, opcodes, register map and the neighbour rule
// ----------------------------------------------------------------------------
package lge_pkg;

   localparam int MAX_SIDE_DEFAULT = 32;

   localparam int SIDE_REG_W = 6;
   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 6'd17;

   localparam int ROW_W = 5;
   localparam int COL_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BOARD_SIDE = 1'b0;

   localparam int NBR_W = 4;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] STAY_COUNT = 4'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic              cell_value;
   } req_type;

   typedef struct packed {
      logic cell_alive;
      logic bad_index;
   } rsp_type;

endpackage

/* rtl/core/life_generation_engine.sv */
// ----------------------------------------------------------------------------
// life_generation_engine
// bounded square life board, one ram row per board row, with cell access and
// a row-by-row generation sweep
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// word appears on rsp_item for one cycle with rsp_strobe and must be taken
// then, the block cannot be held off. A cell write or read first reads the
// row from the board ram, then merges or selects the bit; a bad index, an
// unused opcode or a generation on a board of side 0 is answered straight
// from idle. A generation reads the first row, then sweeps, reading one ram
// row and writing one new row per cycle, with a three-row window of old rows
// held in registers. After reset the board reads as all dead at once,
// through per-row valid bits. The board side register is written over the
// apb port; the user must write it only while idle; the block does not check.
// ----------------------------------------------------------------------------
module life_generation_engine #(
   parameter int MAX_SIDE = lge_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  lge_pkg::req_type                req_item,
   output logic                            rsp_strobe,
   output lge_pkg::rsp_type                rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lge_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lge_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lge_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int ADDR_W = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > lge_pkg::SIDE_REG_W) ? SIDE_W : lge_pkg::SIDE_REG_W;
   localparam int EXT_W  = 7;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CELL,
      S_PRIME,
      S_SWEEP
   } state_type;

   state_type                       state_ff, state_in;
   logic [lge_pkg::SIDE_REG_W-1:0]  side_ff, side_in;
   logic [MAX_SIDE-1:0]             row_valid_ff, row_valid_in;
   logic                            rdv_ff, rdv_in;
   lge_pkg::opcode_type             op_ff, op_in;
   logic [ADDR_W-1:0]               row_ff, row_in;
   logic [ADDR_W-1:0]               col_ff, col_in;
   logic                            val_ff, val_in;
   logic [SIDE_W-1:0]               sweep_ff, sweep_in;
   logic [MAX_SIDE-1:0]             prev_ff, prev_in;
   logic [MAX_SIDE-1:0]             cur_ff, cur_in;
   logic                            strobe_ff, strobe_in;
   lge_pkg::rsp_type                rsp_ff, rsp_in;

   logic [CMP_W-1:0]    side_cmp;
   logic [SIDE_W-1:0]   side_act;
   logic [MAX_SIDE-1:0] col_mask;
   logic                req_bad;
   logic [ADDR_W-1:0]   req_row_idx;
   logic [ADDR_W-1:0]   req_col_idx;
   logic [SIDE_W:0]     rd_sum;
   logic                sweep_last;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [MAX_SIDE-1:0] wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_in_range;
   logic [MAX_SIDE-1:0] rd_data;
   logic [MAX_SIDE-1:0] rd_row;
   logic [MAX_SIDE-1:0] merged_row;
   logic [MAX_SIDE-1:0] new_row;
   logic                csr_write;

   lge_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_board (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lge_row_update #(
      .WIDTH (MAX_SIDE)
   ) u_row_update (
      .above_row (prev_ff),
      .cur_row   (cur_ff),
      .below_row (rd_row),
      .lane_mask (col_mask),
      .new_row   (new_row)
   );

   always_comb begin
      if (CMP_W'(side_ff) > CMP_W'(MAX_SIDE)) begin
         side_cmp = CMP_W'(MAX_SIDE);
      end else begin
         side_cmp = CMP_W'(side_ff);
      end
      side_act = SIDE_W'(side_cmp);
      for (int c = 0; c < MAX_SIDE; c++) begin
         col_mask[c] = SIDE_W'(c) < side_act;
      end
      req_bad     = (CMP_W'(req_item.row) >= side_cmp) || (CMP_W'(req_item.column) >= side_cmp);
      req_row_idx = ADDR_W'(EXT_W'(req_item.row));
      req_col_idx = ADDR_W'(EXT_W'(req_item.column));
      rd_row      = rdv_ff ? rd_data : '0;
      sweep_last  = (SIDE_W'(sweep_ff + SIDE_W'(1)) == side_act);
      merged_row  = rd_row;
      merged_row[col_ff] = val_ff;
   end

   assign csr_write = psel && penable && pwrite
                      && (paddr[lge_pkg::CSR_ADDR_W-1] == lge_pkg::REG_BOARD_SIDE);
   assign pready    = 1'b1;
   assign prdata    = (paddr[lge_pkg::CSR_ADDR_W-1] == lge_pkg::REG_BOARD_SIDE)
                      ? lge_pkg::CSR_DATA_W'(side_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      row_valid_in = row_valid_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      sweep_in     = sweep_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = merged_row;
      rd_addr      = req_row_idx;
      rd_in_range  = 1'b0;
      rd_sum       = '0;

      if (csr_write) begin
         side_in = pwdata[lge_pkg::SIDE_REG_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.opcode)
                  lge_pkg::OP_WRITE, lge_pkg::OP_READ: begin
                     if (req_bad) begin
                        strobe_in         = 1'b1;
                        rsp_in.cell_alive = 1'b0;
                        rsp_in.bad_index  = 1'b1;
                     end else begin
                        rd_addr     = req_row_idx;
                        rd_in_range = 1'b1;
                        op_in       = req_item.opcode;
                        row_in      = req_row_idx;
                        col_in      = req_col_idx;
                        val_in      = req_item.cell_value;
                        state_in    = S_CELL;
                     end
                  end
                  lge_pkg::OP_STEP: begin
                     if (side_act == '0) begin
                        strobe_in         = 1'b1;
                        rsp_in.cell_alive = 1'b0;
                        rsp_in.bad_index  = 1'b0;
                     end else begin
                        rd_addr     = '0;
                        rd_in_range = 1'b1;
                        sweep_in    = '0;
                        prev_in     = '0;
                        state_in    = S_PRIME;
                     end
                  end
                  default: begin
                     strobe_in         = 1'b1;
                     rsp_in.cell_alive = 1'b0;
                     rsp_in.bad_index  = 1'b0;
                  end
               endcase
            end
         end
         S_CELL: begin
            strobe_in        = 1'b1;
            rsp_in.bad_index = 1'b0;
            if (op_ff == lge_pkg::OP_WRITE) begin
               wr_en                = 1'b1;
               wr_addr              = row_ff;
               wr_data              = merged_row;
               row_valid_in[row_ff] = 1'b1;
               rsp_in.cell_alive    = 1'b0;
            end else begin
               rsp_in.cell_alive = rd_row[col_ff];
            end
            state_in = S_IDLE;
         end
         S_PRIME: begin
            cur_in      = rd_row;
            rd_sum      = (SIDE_W+1)'(sweep_ff) + (SIDE_W+1)'(1);
            rd_addr     = rd_sum[ADDR_W-1:0];
            rd_in_range = rd_sum < (SIDE_W+1)'(side_act);
            state_in    = S_SWEEP;
         end
         S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff[ADDR_W-1:0];
            wr_data = new_row;
            row_valid_in[sweep_ff[ADDR_W-1:0]] = 1'b1;
            prev_in     = cur_ff;
            cur_in      = rd_row;
            sweep_in    = SIDE_W'(sweep_ff + SIDE_W'(1));
            rd_sum      = (SIDE_W+1)'(sweep_ff) + (SIDE_W+1)'(2);
            rd_addr     = rd_sum[ADDR_W-1:0];
            rd_in_range = rd_sum < (SIDE_W+1)'(side_act);
            if (sweep_last) begin
               strobe_in         = 1'b1;
               rsp_in.cell_alive = 1'b0;
               rsp_in.bad_index  = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rdv_in = rd_in_range && row_valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= lge_pkg::SIDE_RESET;
         row_valid_ff <= '0;
         rdv_ff       <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         row_valid_ff <= row_valid_in;
         rdv_ff       <= rdv_in;
         strobe_ff    <= strobe_in;
      end
      op_ff    <= op_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      val_ff   <= val_in;
      sweep_ff <= sweep_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* rtl/core/lge_ram.sv */
// ----------------------------------------------------------------------------
// lge_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module lge_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lge_row_update.sv */
// ----------------------------------------------------------------------------
// lge_row_update
// next generation of one board row from the old rows above, at and below it;
// lanes outside the mask count as dead and keep their old value
// ----------------------------------------------------------------------------
module lge_row_update #(
   parameter int WIDTH = lge_pkg::MAX_SIDE_DEFAULT
) (
   input  logic [WIDTH-1:0] above_row,
   input  logic [WIDTH-1:0] cur_row,
   input  logic [WIDTH-1:0] below_row,
   input  logic [WIDTH-1:0] lane_mask,
   output logic [WIDTH-1:0] new_row
);

   localparam int NW = lge_pkg::NBR_W;

   logic [WIDTH+1:0] up_pad;
   logic [WIDTH+1:0] mid_pad;
   logic [WIDTH+1:0] dn_pad;
   logic [NW-1:0]    count [WIDTH];

   always_comb begin
      up_pad  = {1'b0, above_row & lane_mask, 1'b0};
      mid_pad = {1'b0, cur_row & lane_mask, 1'b0};
      dn_pad  = {1'b0, below_row & lane_mask, 1'b0};
      for (int c = 0; c < WIDTH; c++) begin
         count[c] = NW'(up_pad[c]) + NW'(up_pad[c+1]) + NW'(up_pad[c+2])
                  + NW'(mid_pad[c]) + NW'(mid_pad[c+2])
                  + NW'(dn_pad[c]) + NW'(dn_pad[c+1]) + NW'(dn_pad[c+2]);
         if (lane_mask[c]) begin
            new_row[c] = (count[c] == lge_pkg::BIRTH_COUNT)
                       || (cur_row[c] && (count[c] == lge_pkg::STAY_COUNT));
         end else begin
            new_row[c] = cur_row[c];
         end
      end
   end

endmodule
